/* hw/rtl/dp2pc_pkg.sv */
// Shared types, constants and fixed-point helpers for the depth pixel to
// point cloud back-projection pipeline. No dependencies.
`timescale 1ns / 1ps

package dp2pc_pkg;

   // Field widths of the pixel and point beats.
   localparam int COORD_W      = 12;
   localparam int DEPTH_W      = 16;
   localparam int COLOR_W      = 24;
   localparam int POINT_W      = 32;
   localparam int REQ_DATA_W   = 2 * COORD_W + DEPTH_W + COLOR_W;
   localparam int RSP_DATA_W   = 3 * POINT_W + COLOR_W;

   // Configuration register widths and indexes.
   localparam int CSR_DATA_W   = 60;
   localparam int CSR_INDEX_W  = 3;
   localparam int RECIP_W      = 24;
   localparam int PP_W         = 32;
   localparam int COEF_W       = 18;
   localparam int ROT_ROW_W    = 3 * COEF_W;
   localparam int TRANS_W      = 20;
   localparam int TRANS_ALL_W  = 3 * TRANS_W;
   localparam int ZPROD_W      = DEPTH_W + RECIP_W;
   localparam int ROT_PROD_W   = COEF_W + POINT_W;

   localparam logic [CSR_INDEX_W-1:0] REG_INV_FOCAL_X     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_INV_FOCAL_Y     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PRINCIPAL_POINT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DEPTH_TO_METRE  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ROT_ROW_X       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_ROT_ROW_Y       = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_ROT_ROW_Z       = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_TRANSLATION     = 3'd7;

   // Register values after reset.
   localparam logic [RECIP_W-1:0]     RST_INV_FOCAL_X     = 24'd32439;
   localparam logic [RECIP_W-1:0]     RST_INV_FOCAL_Y     = 24'd32482;
   localparam logic [PP_W-1:0]        RST_PRINCIPAL_POINT = 32'd267391078;
   localparam logic [RECIP_W-1:0]     RST_DEPTH_TO_METRE  = 24'd3355;
   localparam logic [ROT_ROW_W-1:0]   RST_ROT_ROW_X       = 54'd65536;
   localparam logic [ROT_ROW_W-1:0]   RST_ROT_ROW_Y       = 54'd17179869184;
   localparam logic [ROT_ROW_W-1:0]   RST_ROT_ROW_Z       = 54'd4503599627370496;
   localparam logic [TRANS_ALL_W-1:0] RST_TRANSLATION     = 60'd0;

   // Default pixel coordinate width and the depth that a point's depth must exceed.
   localparam int COORD_BITS_DEF = 12;
   localparam logic [POINT_W-2:0] Z_MIN = 31'd6;

   // Right shifts of the fixed-point products and left shift of the translation.
   localparam int NORM_SHIFT = 12;
   localparam int MUL_SHIFT  = 16;
   localparam int TRANS_LSH  = 4;

   typedef struct packed {
      logic mul;
      logic sum;
   } stage_en_type;

   // Adds half an LSB, then shifts right with floor.
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                      input int unsigned s);
      logic signed [63:0] r;
      r = (v + (64'sd1 <<< (s - 1))) >>> s;
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

/* hw/rtl/dp2pc_rot_row.sv */
// One row of the pose transform: three coefficient products, then the rounded
// sum plus translation, saturated. Two register stages. Uses dp2pc_pkg.
`timescale 1ns / 1ps

module dp2pc_rot_row (
   input  logic                                   clock,
   input  dp2pc_pkg::stage_en_type                en,
   input  logic [dp2pc_pkg::ROT_ROW_W-1:0]        row_coef,
   input  logic signed [dp2pc_pkg::POINT_W-1:0]   xc,
   input  logic signed [dp2pc_pkg::POINT_W-1:0]   yc,
   input  logic signed [dp2pc_pkg::POINT_W-1:0]   zc,
   input  logic signed [dp2pc_pkg::TRANS_W-1:0]   trans,
   output logic signed [dp2pc_pkg::POINT_W-1:0]   world
);

   logic signed [dp2pc_pkg::ROT_PROD_W-1:0] prod_ff [3];
   logic signed [dp2pc_pkg::ROT_PROD_W-1:0] prod_in [3];
   logic signed [dp2pc_pkg::POINT_W-1:0]    world_ff;
   logic signed [dp2pc_pkg::POINT_W-1:0]    world_in;
   logic signed [dp2pc_pkg::POINT_W-1:0]    cam [3];
   logic signed [63:0]                      acc;
   logic signed [63:0]                      total;

   always_comb begin
      cam[0] = xc;
      cam[1] = yc;
      cam[2] = zc;
      for (int k = 0; k < 3; k++) begin
         prod_in[k] = $signed(row_coef[k*dp2pc_pkg::COEF_W +: dp2pc_pkg::COEF_W]) * cam[k];
      end
   end

   always_comb begin
      acc      = 64'(prod_ff[0]) + 64'(prod_ff[1]) + 64'(prod_ff[2]);
      total    = dp2pc_pkg::round_shift(acc, dp2pc_pkg::MUL_SHIFT)
               + (64'(trans) <<< dp2pc_pkg::TRANS_LSH);
      world_in = dp2pc_pkg::sat32(total);
   end

   always_ff @(posedge clock) begin
      if (en.mul) begin
         prod_ff <= prod_in;
      end
      if (en.sum) begin
         world_ff <= world_in;
      end
   end

   assign world = world_ff;

endmodule

/* hw/rtl/depth_pixel_to_point_cloud.sv */
// Top level of the depth pixel to point cloud pipeline: configuration
// registers, scaling and back-projection stages. Uses dp2pc_pkg, dp2pc_rot_row.
`timescale 1ns / 1ps

// One pixel beat in, at most one point beat out. The pipeline takes a pixel
// in every cycle unless the output stalls; each of the seven register stages
// holds one multiply or one rounding add, and the last stage is the output
// register. Pixels whose depth is at most 0.0001 m are dropped in the second
// stage and leave a bubble. Each stage loads when it is empty or the stage
// after it moves, so a stalled output stops only as many stages as are full
// and loses nothing. Configuration is written through csr_we/csr_index/csr_wdata
// while no pixel is in flight: a rule for the user, not enforced by the block.
module depth_pixel_to_point_cloud #(
   parameter int COORD_BITS = dp2pc_pkg::COORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // column, row, depth_raw, color_bgr (from bit 0 up)
   input  logic [dp2pc_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // point_x, point_y, point_z, color_rgb (from bit 0 up)
   output logic [dp2pc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                  csr_we,
   input  logic [dp2pc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [dp2pc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int USED_W = (COORD_BITS < dp2pc_pkg::COORD_W) ? COORD_BITS
                                                             : dp2pc_pkg::COORD_W;
   localparam int DU_W   = (((USED_W + 4) > 16) ? (USED_W + 4) : 16) + 1;
   localparam int NP_W   = DU_W + dp2pc_pkg::RECIP_W + 1;
   localparam int NSTG   = 7;
   localparam int PW     = dp2pc_pkg::POINT_W;

   // Configuration registers.
   logic [dp2pc_pkg::RECIP_W-1:0]     inv_fx_ff, inv_fy_ff, d2m_ff;
   logic [dp2pc_pkg::PP_W-1:0]        pp_ff;
   logic [dp2pc_pkg::ROT_ROW_W-1:0]   rot_ff [3];
   logic [dp2pc_pkg::TRANS_ALL_W-1:0] trans_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_fx_ff <= dp2pc_pkg::RST_INV_FOCAL_X;
         inv_fy_ff <= dp2pc_pkg::RST_INV_FOCAL_Y;
         pp_ff     <= dp2pc_pkg::RST_PRINCIPAL_POINT;
         d2m_ff    <= dp2pc_pkg::RST_DEPTH_TO_METRE;
         rot_ff[0] <= dp2pc_pkg::RST_ROT_ROW_X;
         rot_ff[1] <= dp2pc_pkg::RST_ROT_ROW_Y;
         rot_ff[2] <= dp2pc_pkg::RST_ROT_ROW_Z;
         trans_ff  <= dp2pc_pkg::RST_TRANSLATION;
      end else if (csr_we) begin
         unique case (csr_index)
            dp2pc_pkg::REG_INV_FOCAL_X:     inv_fx_ff <= csr_wdata[dp2pc_pkg::RECIP_W-1:0];
            dp2pc_pkg::REG_INV_FOCAL_Y:     inv_fy_ff <= csr_wdata[dp2pc_pkg::RECIP_W-1:0];
            dp2pc_pkg::REG_PRINCIPAL_POINT: pp_ff     <= csr_wdata[dp2pc_pkg::PP_W-1:0];
            dp2pc_pkg::REG_DEPTH_TO_METRE:  d2m_ff    <= csr_wdata[dp2pc_pkg::RECIP_W-1:0];
            dp2pc_pkg::REG_ROT_ROW_X:       rot_ff[0] <= csr_wdata[dp2pc_pkg::ROT_ROW_W-1:0];
            dp2pc_pkg::REG_ROT_ROW_Y:       rot_ff[1] <= csr_wdata[dp2pc_pkg::ROT_ROW_W-1:0];
            dp2pc_pkg::REG_ROT_ROW_Z:       rot_ff[2] <= csr_wdata[dp2pc_pkg::ROT_ROW_W-1:0];
            dp2pc_pkg::REG_TRANSLATION:     trans_ff  <= csr_wdata;
         endcase
      end
   end

   // Beat fields.
   logic [dp2pc_pkg::COORD_W-1:0] req_column, req_row;
   logic [dp2pc_pkg::DEPTH_W-1:0] req_depth;
   logic [dp2pc_pkg::COLOR_W-1:0] req_bgr;

   assign req_column = req_tdata[dp2pc_pkg::COORD_W-1:0];
   assign req_row    = req_tdata[2*dp2pc_pkg::COORD_W-1:dp2pc_pkg::COORD_W];
   assign req_depth  = req_tdata[2*dp2pc_pkg::COORD_W +: dp2pc_pkg::DEPTH_W];
   assign req_bgr    = req_tdata[dp2pc_pkg::REQ_DATA_W-1 -: dp2pc_pkg::COLOR_W];

   // Stage handshake: a stage loads when it is empty or its successor moves.
   logic [NSTG:1] vld_ff, vld_in, rdy;
   logic          keep;

   always_comb begin
      rdy[NSTG] = ~vld_ff[NSTG] | rsp_tready;
      for (int k = NSTG - 1; k >= 1; k--) begin
         rdy[k] = ~vld_ff[k] | rdy[k+1];
      end
      vld_in[1] = req_tvalid;
      vld_in[2] = vld_ff[1] & keep;
      for (int k = 3; k <= NSTG; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 1; k <= NSTG; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   // The colour is reordered on entry and rides along with the point.
   logic [dp2pc_pkg::COLOR_W-1:0] rgb_ff [1:NSTG];

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         rgb_ff[1] <= {req_bgr[7:0], req_bgr[15:8], req_bgr[23:16]};
      end
      for (int k = 2; k <= NSTG; k++) begin
         if (rdy[k]) begin
            rgb_ff[k] <= rgb_ff[k-1];
         end
      end
   end

   // Stage 1: raw depth times scale, pixel offsets from the principal point.
   logic [dp2pc_pkg::ZPROD_W-1:0] zprod_ff, zprod_in;
   logic signed [DU_W-1:0]        du_ff, du_in, dv_ff, dv_in;

   always_comb begin
      zprod_in = req_depth * d2m_ff;
      du_in    = DU_W'($signed({1'b0, req_column[USED_W-1:0], 4'b0000}))
               - DU_W'($signed({1'b0, pp_ff[15:0]}));
      dv_in    = DU_W'($signed({1'b0, req_row[USED_W-1:0], 4'b0000}))
               - DU_W'($signed({1'b0, pp_ff[31:16]}));
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         zprod_ff <= zprod_in;
         du_ff    <= du_in;
         dv_ff    <= dv_in;
      end
   end

   // Stage 2: depth in unsigned Q15.16 and the threshold test; offsets times 1/f.
   logic [dp2pc_pkg::ZPROD_W:0]   zsum;
   logic [PW:0]                   zq;
   logic [PW-2:0]                 z_in, z2_ff, z3_ff, z4_ff;
   logic signed [NP_W-1:0]        pu_ff, pu_in, pv_ff, pv_in;

   always_comb begin
      zsum  = {1'b0, zprod_ff} + (dp2pc_pkg::ZPROD_W + 1)'(128);
      zq    = zsum[dp2pc_pkg::ZPROD_W:8];
      z_in  = (zq[PW] | zq[PW-1]) ? '1 : zq[PW-2:0];
      keep  = z_in > dp2pc_pkg::Z_MIN;
      pu_in = du_ff * $signed({1'b0, inv_fx_ff});
      pv_in = dv_ff * $signed({1'b0, inv_fy_ff});
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         z2_ff <= z_in;
         pu_ff <= pu_in;
         pv_ff <= pv_in;
      end
   end

   // Stage 3: normalized coordinates, rounded and saturated to Q16.16.
   logic signed [PW-1:0] un_ff, un_in, vn_ff, vn_in;

   always_comb begin
      un_in = dp2pc_pkg::sat32(dp2pc_pkg::round_shift(64'(pu_ff), dp2pc_pkg::NORM_SHIFT));
      vn_in = dp2pc_pkg::sat32(dp2pc_pkg::round_shift(64'(pv_ff), dp2pc_pkg::NORM_SHIFT));
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         z3_ff <= z2_ff;
         un_ff <= un_in;
         vn_ff <= vn_in;
      end
   end

   // Stage 4: normalized coordinates times depth.
   logic signed [63:0] xp_ff, xp_in, yp_ff, yp_in;

   always_comb begin
      xp_in = un_ff * $signed({1'b0, z3_ff});
      yp_in = vn_ff * $signed({1'b0, z3_ff});
   end

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         z4_ff <= z3_ff;
         xp_ff <= xp_in;
         yp_ff <= yp_in;
      end
   end

   // Stage 5: camera-frame point, rounded and saturated.
   logic signed [PW-1:0] xc_ff, xc_in, yc_ff, yc_in, zc_ff;

   always_comb begin
      xc_in = dp2pc_pkg::sat32(dp2pc_pkg::round_shift(xp_ff, dp2pc_pkg::MUL_SHIFT));
      yc_in = dp2pc_pkg::sat32(dp2pc_pkg::round_shift(yp_ff, dp2pc_pkg::MUL_SHIFT));
   end

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         xc_ff <= xc_in;
         yc_ff <= yc_in;
         zc_ff <= $signed({1'b0, z4_ff});
      end
   end

   // Stages 6 and 7: pose transform, one unit per world axis.
   dp2pc_pkg::stage_en_type rot_en;
   logic signed [PW-1:0]    world [3];

   assign rot_en.mul = rdy[6];
   assign rot_en.sum = rdy[7];

   for (genvar i = 0; i < 3; i++) begin : g_row
      dp2pc_rot_row u_rot_row (
         .clock    (clock),
         .en       (rot_en),
         .row_coef (rot_ff[i]),
         .xc       (xc_ff),
         .yc       (yc_ff),
         .zc       (zc_ff),
         .trans    ($signed(trans_ff[i*dp2pc_pkg::TRANS_W +: dp2pc_pkg::TRANS_W])),
         .world    (world[i])
      );
   end

   assign req_tready = rdy[1];
   assign rsp_tvalid = vld_ff[NSTG];
   assign rsp_tdata  = {rgb_ff[NSTG], world[2], world[1], world[0]};

endmodule
